// ===== rtl/core/ttic_pkg.sv =====
// Package for the typed text item checker: value type codes, register
// indexes, character codes and length constants.
// Depends on nothing; imported by typed_text_item_checker.
package ttic_pkg;

   // Width of the internal character counter, which saturates at its top value.
   localparam int LENGTH_BITS = 16;
   // Width of the length fields on the ports and in the registers.
   localparam int LEN_FIELD_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [LENGTH_BITS-1:0] COUNT_TOP = '1;

   typedef enum logic [2:0] {
      VT_UNCHECKED = 3'd0,
      VT_BOOL      = 3'd1,
      VT_INT       = 3'd2,
      VT_UINT      = 3'd3,
      VT_DECIMAL   = 3'd4,
      VT_DATE      = 3'd5,
      VT_TIME      = 3'd6,
      VT_DATETIME  = 3'd7
   } value_type_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VALUE_TYPE = 2'd0,
      CSR_MIN_LENGTH = 2'd1,
      CSR_MAX_LENGTH = 2'd2
   } csr_index_type;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int DATE_LEN     = 8;
   localparam int TIME_LEN     = 6;
   localparam int DATETIME_LEN = 14;

endpackage

// ===== rtl/core/typed_text_item_checker.sv =====
// Typed text item checker: checks a stream of characters against a configured
// value type and reports the verdict and length at the end of each item.
// Depends on ttic_pkg.

// The block takes one character beat per cycle on the req_ channel and, on the
// beat that carries req_last_char, produces one result beat on the rsp_
// channel in the cycle after it with the type verdict, the too-short and
// too-long flags and the saturated item length. The per-character flag update
// and the end-of-item checks are a short piece of logic between the item
// state registers and the result register, so a new beat is accepted in every
// cycle while the result register is empty or being taken.
// The input channel is stalled only while a result is held by rsp_stall. A
// beat with req_has_char low adds no character, so an item made only of such
// beats is empty and fails the type check. Each character is judged by the
// value type in force when it arrives; the end checks use the type in force
// on the last beat. Configuration writes are always taken (csr_ready is high)
// and should be made only while the block is idle; writes to an index beyond
// the three registers are ignored.
module typed_text_item_checker
   import ttic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_char_code,
   input  logic                      req_has_char,
   input  logic                      req_last_char,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_type_ok,
   output logic                      rsp_too_short,
   output logic                      rsp_too_long,
   output logic [LEN_FIELD_BITS-1:0] rsp_item_length,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // Configuration registers.
   value_type_type            value_type_ff;
   logic [LEN_FIELD_BITS-1:0] min_length_ff;
   logic [LEN_FIELD_BITS-1:0] max_length_ff;

   // Per-item state and its next values.
   logic [LENGTH_BITS-1:0] char_count_ff, char_count_in;
   logic                   format_valid_ff, format_valid_in;
   logic                   dot_seen_ff, dot_seen_in;
   logic                   digit_seen_ff, digit_seen_in;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      type_ok_ff, type_ok_in;
   logic                      too_short_ff, too_short_in;
   logic                      too_long_ff, too_long_in;
   logic [LEN_FIELD_BITS-1:0] item_length_ff;

   logic req_accept;
   logic is_digit;
   logic is_first;
   logic shape_ok;

   assign csr_ready  = 1'b1;
   // The input channel is only ever stalled by a held result beat.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign is_digit = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign is_first = (char_count_ff == '0);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_type_ff <= VT_UNCHECKED;
         min_length_ff <= '0;
         max_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VALUE_TYPE: begin
               value_type_ff <= value_type_type'(csr_data[2:0]);
            end
            CSR_MIN_LENGTH: begin
               min_length_ff <= LEN_FIELD_BITS'(csr_data);
            end
            CSR_MAX_LENGTH: begin
               max_length_ff <= LEN_FIELD_BITS'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   // Character update: the flags are folded in with the incoming character,
   // and the end-of-item checks look at the updated values so that the last
   // character counts.
   always_comb begin
      char_count_in   = char_count_ff;
      format_valid_in = format_valid_ff;
      dot_seen_in     = dot_seen_ff;
      digit_seen_in   = digit_seen_ff;

      if (req_has_char) begin
         case (value_type_ff)
            VT_BOOL: begin
               if (!is_first || !(req_char_code == CHAR_ZERO || req_char_code == CHAR_ONE)) begin
                  format_valid_in = 1'b0;
               end
            end
            VT_INT: begin
               if (!(is_first && req_char_code == CHAR_MINUS) && !is_digit) begin
                  format_valid_in = 1'b0;
               end
            end
            VT_DECIMAL: begin
               if (is_first && req_char_code == CHAR_MINUS) begin
                  // A leading minus is allowed and changes nothing else.
               end else if (req_char_code == CHAR_DOT) begin
                  if (dot_seen_ff) begin
                     format_valid_in = 1'b0;
                  end
                  dot_seen_in = 1'b1;
               end else if (!is_digit) begin
                  format_valid_in = 1'b0;
               end
            end
            VT_UINT, VT_DATE, VT_TIME, VT_DATETIME: begin
               if (!is_digit) begin
                  format_valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
         if (is_digit) begin
            digit_seen_in = 1'b1;
         end
         if (char_count_ff != COUNT_TOP) begin
            char_count_in = char_count_ff + 1'b1;
         end
      end

      case (value_type_ff)
         VT_BOOL: begin
            shape_ok = (char_count_in == LENGTH_BITS'(1));
         end
         VT_INT, VT_DECIMAL: begin
            shape_ok = digit_seen_in;
         end
         VT_DATE: begin
            shape_ok = (char_count_in == LENGTH_BITS'(DATE_LEN));
         end
         VT_TIME: begin
            shape_ok = (char_count_in == LENGTH_BITS'(TIME_LEN));
         end
         VT_DATETIME: begin
            shape_ok = (char_count_in == LENGTH_BITS'(DATETIME_LEN));
         end
         default: begin
            shape_ok = 1'b1;
         end
      endcase

      type_ok_in   = (char_count_in != '0) && format_valid_in && shape_ok;
      // Both sides are widened to 32 bits so the compare holds for any counter width up to 32 bits.
      too_short_in = type_ok_in && (min_length_ff != '0) &&
                     (32'(char_count_in) < 32'(min_length_ff));
      too_long_in  = type_ok_in && (max_length_ff != '0) &&
                     (32'(char_count_in) > 32'(max_length_ff));
   end

   // Item state: cleared after the last beat of each item.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff   <= '0;
         format_valid_ff <= 1'b1;
         dot_seen_ff     <= 1'b0;
         digit_seen_ff   <= 1'b0;
      end else if (req_accept) begin
         if (req_last_char) begin
            char_count_ff   <= '0;
            format_valid_ff <= 1'b1;
            dot_seen_ff     <= 1'b0;
            digit_seen_ff   <= 1'b0;
         end else begin
            char_count_ff   <= char_count_in;
            format_valid_ff <= format_valid_in;
            dot_seen_ff     <= dot_seen_in;
            digit_seen_ff   <= digit_seen_in;
         end
      end
   end

   // Result valid: set by a last beat, cleared once the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept && req_last_char) begin
         type_ok_ff     <= type_ok_in;
         too_short_ff   <= too_short_in;
         too_long_ff    <= too_long_in;
         item_length_ff <= LEN_FIELD_BITS'(char_count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_type_ok     = type_ok_ff;
   assign rsp_too_short   = too_short_ff;
   assign rsp_too_long    = too_long_ff;
   assign rsp_item_length = item_length_ff;

   // A last beat always leaves a result waiting in the next cycle.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_char |=> rsp_valid_ff)
      else $error("last beat did not produce a result");

   // The length flags are only ever raised on an item that passed the type check.
   a_flags_need_type_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (too_short_ff || too_long_ff) |-> type_ok_ff)
      else $error("length flag raised without type pass");

   // The item state starts afresh after every last beat.
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_char |=>
         char_count_ff == '0 && format_valid_ff && !dot_seen_ff && !digit_seen_ff)
      else $error("item state not cleared after last beat");

   // Within an item the counter never goes backwards.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_last_char |=> char_count_ff >= $past(char_count_ff))
      else $error("character count went backwards within an item");

   // A failed type check is never repaired later in the same item.
   a_format_sticky: assert property (@(posedge clock) disable iff (reset)
      !format_valid_ff && req_accept && !req_last_char |=> !format_valid_ff)
      else $error("format flag recovered within an item");

endmodule
